/* rtl/dual_wheel_velocity_pid_top_defines.svh */
// Assertion macros for the speed regulator RTL (included by dwvp_ctrl).
// Expects signals named clock and reset in the including module.
`ifndef DUAL_WHEEL_VELOCITY_PID_TOP_DEFINES_SVH
`define DUAL_WHEEL_VELOCITY_PID_TOP_DEFINES_SVH

// same-cycle implication
`define DWVP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dwvp assertion failed");

// next-cycle implication
`define DWVP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dwvp assertion failed");

`endif

/* rtl/dwvp_pkg.sv */
// Types and constants of the dual wheel speed regulator.
// No dependencies.
package dwvp_pkg;

   localparam logic [25:0] RPM_SCALE = 26'd60000000;

   typedef struct packed {
      logic [31:0]        count_left;
      logic [31:0]        count_right;
      logic [19:0]        elapsed_us;
      logic signed [23:0] target_left_rpm;
      logic signed [23:0] target_right_rpm;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive_left;
      logic signed [15:0] drive_right;
      logic signed [23:0] speed_left_rpm;
      logic signed [23:0] speed_right_rpm;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic signed [15:0] drive_min;
      logic [14:0]        drive_max;
      logic [15:0]        ticks_per_turn;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_GAIN_P    = 3'd0,
      REG_GAIN_I    = 3'd1,
      REG_GAIN_D    = 3'd2,
      REG_DRIVE_MIN = 3'd3,
      REG_DRIVE_MAX = 3'd4,
      REG_TICKS     = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      MUL_DEN = 3'd0,
      MUL_NUM = 3'd1,
      MUL_KP  = 3'd2,
      MUL_KI  = 3'd3,
      MUL_KD  = 3'd4
   } mul_sel_type;

   typedef struct packed {
      logic        req_load;
      logic        wheel;
      mul_sel_type mul_sel;
      logic        den_load;
      logic        div_load;
      logic        div_step;
      logic        speed_store;
      logic        err_store;
      logic        sum_load;
      logic        sum_add;
      logic        drive_store;
      logic        out_load;
   } cmd_type;

endpackage

/* rtl/dwvp_csr.sv */
// Configuration registers behind the APB-style port.
// Depends on dwvp_pkg.
module dwvp_csr
   import dwvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_GAIN_P:    cfg_in.gain_p         = csr_pwdata[15:0];
            REG_GAIN_I:    cfg_in.gain_i         = csr_pwdata[15:0];
            REG_GAIN_D:    cfg_in.gain_d         = csr_pwdata[15:0];
            REG_DRIVE_MIN: cfg_in.drive_min      = csr_pwdata[15:0];
            REG_DRIVE_MAX: cfg_in.drive_max      = csr_pwdata[14:0];
            REG_TICKS:     cfg_in.ticks_per_turn = csr_pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_GAIN_P:    csr_prdata = {{16{cfg_ff.gain_p[15]}}, cfg_ff.gain_p};
         REG_GAIN_I:    csr_prdata = {{16{cfg_ff.gain_i[15]}}, cfg_ff.gain_i};
         REG_GAIN_D:    csr_prdata = {{16{cfg_ff.gain_d[15]}}, cfg_ff.gain_d};
         REG_DRIVE_MIN: csr_prdata = {{16{cfg_ff.drive_min[15]}}, cfg_ff.drive_min};
         REG_DRIVE_MAX: csr_prdata = {17'd0, cfg_ff.drive_max};
         REG_TICKS:     csr_prdata = {16'd0, cfg_ff.ticks_per_turn};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= 16'sd256;
         cfg_ff.gain_i         <= 16'sd0;
         cfg_ff.gain_d         <= 16'sd0;
         cfg_ff.drive_min      <= -16'sd255;
         cfg_ff.drive_max      <= 15'd255;
         cfg_ff.ticks_per_turn <= 16'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/dwvp_ctrl.sv */
// Sequencer of the speed regulator: steps the shared multiplier, the serial
// divider and the PID sum for each wheel. Depends on dwvp_pkg and the defines.
`include "dual_wheel_velocity_pid_top_defines.svh"
module dwvp_ctrl
   import dwvp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_DEN    = 13'b0000000000010,
      ST_NUM    = 13'b0000000000100,
      ST_LOAD   = 13'b0000000001000,
      ST_DIV    = 13'b0000000010000,
      ST_SPEED  = 13'b0000000100000,
      ST_ERR    = 13'b0000001000000,
      ST_MP     = 13'b0000010000000,
      ST_MI     = 13'b0000100000000,
      ST_MD     = 13'b0001000000000,
      ST_MS     = 13'b0010000000000,
      ST_DRIVE  = 13'b0100000000000,
      ST_FINISH = 13'b1000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       wheel_ff, wheel_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      wheel_in     = wheel_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.wheel    = wheel_ff;
      cmd.mul_sel  = MUL_DEN;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               wheel_in     = 1'b0;
               state_in     = ST_DEN;
            end
         end
         ST_DEN: begin
            cmd.mul_sel = MUL_DEN;
            state_in    = ST_NUM;
         end
         ST_NUM: begin
            cmd.mul_sel  = MUL_NUM;
            cmd.den_load = !wheel_ff;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = 5'd23;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            cmd.speed_store = 1'b1;
            state_in        = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_store = 1'b1;
            state_in      = ST_MP;
         end
         ST_MP: begin
            cmd.mul_sel = MUL_KP;
            state_in    = ST_MI;
         end
         ST_MI: begin
            cmd.mul_sel  = MUL_KI;
            cmd.sum_load = 1'b1;
            state_in     = ST_MD;
         end
         ST_MD: begin
            cmd.mul_sel = MUL_KD;
            cmd.sum_add = 1'b1;
            state_in    = ST_MS;
         end
         ST_MS: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_DRIVE;
         end
         ST_DRIVE: begin
            cmd.drive_store = 1'b1;
            if (wheel_ff) begin
               state_in = ST_FINISH;
            end else begin
               wheel_in = 1'b1;
               state_in = ST_NUM;
            end
         end
         ST_FINISH: begin
            // hold until the previous result has left the output register
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wheel_ff     <= 1'b0;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DWVP_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_DEN)
   `DWVP_ASSERT_NEXT(a_div_ends, state_ff == ST_DIV && cnt_ff == 5'd0, state_ff == ST_SPEED)
   `DWVP_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))
   `DWVP_ASSERT_NEXT(a_right_then_finish, state_ff == ST_DRIVE && wheel_ff,
                     state_ff == ST_FINISH)

endmodule

/* rtl/dwvp_datapath.sv */
// Datapath of the speed regulator: shared multiplier, restoring divider,
// PID arithmetic and per-wheel state. Depends on dwvp_pkg.
module dwvp_datapath
   import dwvp_pkg::*;
#(
   parameter int COUNT_BITS      = 32,
   parameter int SPEED_FRAC_BITS = 8
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  cfg_type cfg,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int NUM0_W = COUNT_BITS + 26;
   localparam int NUM_W  = NUM0_W + SPEED_FRAC_BITS;
   localparam int DIV_W  = (NUM_W > 61) ? NUM_W : 61;
   localparam int SUM_SH = 8 + SPEED_FRAC_BITS;
   localparam logic signed [28:0] SPD_MAX29 = 29'sd8388607;
   localparam logic signed [28:0] SPD_MIN29 = -29'sd8388608;

   req_type            req_ff;
   logic signed [59:0] prod_ff;
   logic [35:0]        den_ff;
   logic [DIV_W-1:0]   rem_ff, dsh_ff;
   logic [23:0]        quo_ff;
   logic               ovf_ff, zero_ff;
   logic signed [23:0] speed_ff [2];
   logic signed [24:0] err_ff;
   logic signed [23:0] a_ff;
   logic signed [25:0] der_ff;
   logic signed [43:0] sum_ff;
   logic signed [15:0] drive_ff [2];
   logic [COUNT_BITS-1:0] last_ff [2];
   logic signed [24:0] prior_ff [2];
   logic signed [23:0] accum_ff [2];
   rsp_type            rsp_ff;

   logic [COUNT_BITS-1:0] cnt_w, delta, mag_w;
   logic                  neg;
   logic signed [32:0]    ma;
   logic signed [26:0]    mb;
   logic signed [59:0]    prod;
   logic [DIV_W-1:0]      num_sh, den24;
   logic signed [24:0]    quo_s;
   logic signed [23:0]    spd_next, tgt, spd;
   logic signed [24:0]    err_next;
   logic signed [28:0]    lo_raw, hi_raw;
   logic signed [25:0]    lo26, hi26, a_raw, a_clamp;
   logic signed [23:0]    a_next;
   logic signed [25:0]    der_next;
   logic signed [43:0]    shifted, quot, lo44, hi44;
   logic                  rnd;
   logic signed [15:0]    drive_next;

   assign rsp_data = rsp_ff;

   // encoder delta, modulo the count width, as sign and magnitude
   assign cnt_w = cmd.wheel ? req_ff.count_right[COUNT_BITS-1:0]
                            : req_ff.count_left[COUNT_BITS-1:0];
   assign delta = cnt_w - last_ff[cmd.wheel];
   assign neg   = delta[COUNT_BITS-1];
   assign mag_w = neg ? COUNT_BITS'(~delta + 1'b1) : delta;

   always_comb begin
      case (cmd.mul_sel)
         MUL_DEN: begin
            ma = $signed({17'd0, cfg.ticks_per_turn});
            mb = $signed({7'd0, req_ff.elapsed_us});
         end
         MUL_NUM: begin
            ma = $signed({{(33 - COUNT_BITS){1'b0}}, mag_w});
            mb = $signed({1'b0, RPM_SCALE});
         end
         MUL_KP: begin
            ma = {{17{cfg.gain_p[15]}}, cfg.gain_p};
            mb = {{2{err_ff[24]}}, err_ff};
         end
         MUL_KI: begin
            ma = {{17{cfg.gain_i[15]}}, cfg.gain_i};
            mb = {{3{a_ff[23]}}, a_ff};
         end
         MUL_KD: begin
            ma = {{17{cfg.gain_d[15]}}, cfg.gain_d};
            mb = {der_ff[25], der_ff};
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   assign prod = ma * mb;

   // scaled numerator, and divisor placed just above the top quotient bit for the overflow test
   assign num_sh = DIV_W'(prod_ff[NUM0_W-1:0]) << SPEED_FRAC_BITS;
   assign den24  = DIV_W'(den_ff) << 24;

   assign quo_s = $signed({1'b0, quo_ff});
   always_comb begin
      if (zero_ff) begin
         spd_next = '0;
      end else if (!neg) begin
         spd_next = (ovf_ff || quo_ff > 24'd8388607) ? 24'sh7FFFFF : $signed(quo_ff);
      end else begin
         spd_next = (ovf_ff || quo_ff > 24'd8388608) ? 24'sh800000 : 24'(-quo_s);
      end
   end

   assign tgt      = cmd.wheel ? req_ff.target_right_rpm : req_ff.target_left_rpm;
   assign spd      = speed_ff[cmd.wheel];
   assign err_next = {tgt[23], tgt} - {spd[23], spd};
   assign der_next = {err_next[24], err_next} - {prior_ff[cmd.wheel][24], prior_ff[cmd.wheel]};

   assign lo_raw = $signed({{13{cfg.drive_min[15]}}, cfg.drive_min}) <<< SPEED_FRAC_BITS;
   assign hi_raw = $signed({14'd0, cfg.drive_max}) <<< SPEED_FRAC_BITS;
   assign lo26   = (lo_raw < SPD_MIN29) ? 26'(SPD_MIN29) : 26'(lo_raw);
   assign hi26   = (hi_raw > SPD_MAX29) ? 26'(SPD_MAX29) : 26'(hi_raw);
   assign a_raw  = {{2{accum_ff[cmd.wheel][23]}}, accum_ff[cmd.wheel]}
                 + {err_next[24], err_next};

   always_comb begin
      if (a_raw > hi26) begin
         a_clamp = hi26;
      end else if (a_raw < lo26) begin
         a_clamp = lo26;
      end else begin
         a_clamp = a_raw;
      end
      // zero target held exactly: drop the integral
      if (tgt == 24'sd0 && err_next == 25'sd0) begin
         a_next = '0;
      end else begin
         a_next = a_clamp[23:0];
      end
   end

   // truncate toward zero, then clamp to the drive limits
   assign shifted = sum_ff >>> SUM_SH;
   assign rnd     = sum_ff[43] && (sum_ff[SUM_SH-1:0] != '0);
   assign quot    = shifted + 44'(rnd);
   assign lo44    = {{28{cfg.drive_min[15]}}, cfg.drive_min};
   assign hi44    = {29'd0, cfg.drive_max};
   always_comb begin
      if (quot < lo44) begin
         drive_next = cfg.drive_min;
      end else if (quot > hi44) begin
         drive_next = $signed({1'b0, cfg.drive_max});
      end else begin
         drive_next = quot[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      prod_ff <= prod;
      if (cmd.den_load) begin
         den_ff <= prod_ff[35:0];
      end
      if (cmd.div_load) begin
         rem_ff  <= num_sh;
         dsh_ff  <= DIV_W'(den_ff) << 23;
         quo_ff  <= '0;
         ovf_ff  <= (num_sh >= den24);
         zero_ff <= (den_ff == '0) || (mag_w == '0);
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[22:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[22:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.speed_store) begin
         speed_ff[cmd.wheel] <= spd_next;
      end
      if (cmd.err_store) begin
         err_ff <= err_next;
         a_ff   <= a_next;
         der_ff <= der_next;
      end
      if (cmd.sum_load) begin
         sum_ff <= prod_ff[43:0];
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + prod_ff[43:0];
      end
      if (cmd.drive_store) begin
         drive_ff[cmd.wheel] <= drive_next;
      end
      if (cmd.out_load) begin
         rsp_ff.drive_left      <= drive_ff[0];
         rsp_ff.drive_right     <= drive_ff[1];
         rsp_ff.speed_left_rpm  <= speed_ff[0];
         rsp_ff.speed_right_rpm <= speed_ff[1];
      end
   end

   // per-wheel loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff[0]  <= '0;
         last_ff[1]  <= '0;
         prior_ff[0] <= '0;
         prior_ff[1] <= '0;
         accum_ff[0] <= '0;
         accum_ff[1] <= '0;
      end else if (cmd.drive_store) begin
         last_ff[cmd.wheel]  <= cnt_w;
         prior_ff[cmd.wheel] <= err_ff;
         accum_ff[cmd.wheel] <= a_ff;
      end
   end

endmodule

/* rtl/dual_wheel_velocity_pid_top.sv */
// Channel   Ports                    Payload
// request   req_valid/req_ready      req_data (req_type)
// response  rsp_valid/rsp_ready      rsp_data (rsp_type)
// config    csr_psel..csr_pready     6 registers at byte address 4*i
//
// A request runs from acceptance to its response being loaded through one
// shared 33x27 multiplier and a 24-step restoring divider, left wheel then
// right wheel. Reset is synchronous and needs no clearing pass. A waiting
// response holds the sequencer in its last step; requests are taken only
// while the sequencer is idle.
// Depends on dwvp_pkg, dwvp_csr, dwvp_ctrl and dwvp_datapath.
module dual_wheel_velocity_pid_top
   import dwvp_pkg::*;
#(
   parameter int COUNT_BITS      = 32,
   parameter int SPEED_FRAC_BITS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   cmd_type cmd;

   dwvp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dwvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dwvp_datapath #(
      .COUNT_BITS      (COUNT_BITS),
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
